// File: rtl/core/ptm_pkg.sv
package ptm_pkg;

   localparam int unsigned FIRE_W = 10;

   localparam logic [31:0] NO_ACTIVE_MIN = 32'hffff_ffff;

   typedef enum logic [1:0] {
      OP_SET     = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_COMPARE = 2'd2,
      OP_QUERY   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_ID   = 2'd1,
      STATUS_INACTIVE = 2'd2
   } status_type;

   typedef logic [FIRE_W-1:0] fire_mask_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  slot_id;
      logic [31:0] interval_us;
      logic [31:0] counter_now;
   } req_payload_type;

   typedef struct packed {
      status_type    status;
      logic          compare_valid;
      logic [31:0]   compare_value;
      fire_mask_type fired_mask;
      logic          irq_clear;
      logic [31:0]   entry_interval;
      logic [31:0]   entry_remaining;
      logic [31:0]   entry_fire_count;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FIND   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// File: rtl/core/ptm_channel_if.sv
interface ptm_channel_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/periodic_timer_multiplexer.sv
// Periodic timer multiplexer: NUM_TIMERS periodic timers share the compare register of one
// free-running 32-bit counter. Each request beat carries one operation and yields exactly one
// response beat. All work is done by one sequencer that walks the timer table one entry per
// cycle through its subtract and compare logic. A set makes one ageing pass over the table, a
// compare event makes a pass to find the least remaining time, then a pass that subtracts,
// reloads and finds the next least, and a remove, a query or a set with an out-of-range timer
// goes straight to the finish step. The response sits in an output register, so a new request
// is taken while the previous response still waits; the block only waits when a finished
// response finds the previous one not yet taken.
module periodic_timer_multiplexer #(
   parameter int NUM_TIMERS = 10
) (
   input  logic          clock,
   input  logic          reset,
   ptm_channel_if.sink   req_chan,
   ptm_channel_if.source rsp_chan
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   logic [31:0] interval_ff  [NUM_TIMERS];
   logic [31:0] remaining_ff [NUM_TIMERS];
   logic [31:0] count_ff     [NUM_TIMERS];
   logic [31:0] last_ff;

   ptm_pkg::state_type       state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [IDX_W-1:0]         id_ff, id_in;
   ptm_pkg::op_type          op_ff, op_in;
   logic                     err_ff, err_in;
   logic [31:0]              ival_ff, ival_in;
   logic [31:0]              now_ff, now_in;
   logic [31:0]              diff_ff, diff_in;
   logic [31:0]              least_ff, least_in;
   logic [31:0]              min_ff, min_in;
   ptm_pkg::fire_mask_type   mask_ff, mask_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ptm_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic        wr_en;
   logic [31:0] wr_interval, wr_remaining, wr_count;
   logic        last_en;
   logic [31:0] rd_interval, rd_remaining, rd_count;
   logic        rd_active, idx_last;
   logic        cand_en;
   logic [31:0] cand;
   logic [31:0] aged;
   logic        req_fire;

   assign rd_interval  = interval_ff[idx_ff];
   assign rd_remaining = remaining_ff[idx_ff];
   assign rd_count     = count_ff[idx_ff];
   assign rd_active    = (rd_interval != 32'd0);
   assign idx_last     = (idx_ff == IDX_W'(NUM_TIMERS - 1));

   assign req_chan.ready   = (state_ff == ptm_pkg::ST_IDLE);
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      id_in        = id_ff;
      op_in        = op_ff;
      err_in       = err_ff;
      ival_in      = ival_ff;
      now_in       = now_ff;
      diff_in      = diff_ff;
      least_in     = least_ff;
      min_in       = min_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_interval  = rd_interval;
      wr_remaining = rd_remaining;
      wr_count     = rd_count;
      last_en      = 1'b0;
      cand_en      = 1'b0;
      cand         = 32'd0;
      aged         = 32'd0;

      unique case (state_ff)
         ptm_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.payload.operation;
               id_in    = req_chan.payload.slot_id[IDX_W-1:0];
               ival_in  = req_chan.payload.interval_us;
               now_in   = req_chan.payload.counter_now;
               diff_in  = req_chan.payload.counter_now - last_ff;
               err_in   = 1'b0;
               idx_in   = '0;
               min_in   = ptm_pkg::NO_ACTIVE_MIN;
               mask_in  = '0;
               if (req_chan.payload.operation == ptm_pkg::OP_COMPARE) begin
                  state_in = ptm_pkg::ST_FIND;
               end else if (32'(req_chan.payload.slot_id) >= 32'(NUM_TIMERS)) begin
                  err_in   = 1'b1;
                  state_in = ptm_pkg::ST_FINISH;
               end else if (req_chan.payload.operation == ptm_pkg::OP_SET) begin
                  state_in = ptm_pkg::ST_UPDATE;
               end else begin
                  idx_in   = req_chan.payload.slot_id[IDX_W-1:0];
                  state_in = ptm_pkg::ST_FINISH;
               end
            end
         end

         ptm_pkg::ST_FIND: begin
            cand = (rd_active && rd_remaining < min_ff) ? rd_remaining : min_ff;
            if (idx_last) begin
               least_in = cand;
               min_in   = ptm_pkg::NO_ACTIVE_MIN;
               idx_in   = '0;
               state_in = ptm_pkg::ST_UPDATE;
            end else begin
               min_in = cand;
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ptm_pkg::ST_UPDATE: begin
            if (op_ff == ptm_pkg::OP_SET) begin
               if (idx_ff == id_ff) begin
                  wr_en        = 1'b1;
                  wr_interval  = ival_ff;
                  wr_remaining = ival_ff;
                  wr_count     = 32'd0;
                  cand_en      = (ival_ff != 32'd0);
                  cand         = ival_ff;
               end else if (rd_active) begin
                  aged         = rd_remaining - diff_ff;
                  wr_en        = 1'b1;
                  wr_remaining = aged;
                  cand_en      = 1'b1;
                  cand         = aged;
               end
            end else if (rd_active) begin
               aged    = rd_remaining - least_ff;
               wr_en   = 1'b1;
               cand_en = 1'b1;
               if (aged == 32'd0) begin
                  wr_remaining = rd_interval;
                  wr_count     = rd_count + 32'd1;
                  mask_in      = mask_ff | (ptm_pkg::fire_mask_type'(1) << idx_ff);
                  cand         = rd_interval;
               end else begin
                  wr_remaining = aged;
                  cand         = aged;
               end
            end
            if (cand_en && cand < min_ff) begin
               min_in = cand;
            end
            if (idx_last) begin
               state_in = ptm_pkg::ST_FINISH;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ptm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               state_in     = ptm_pkg::ST_IDLE;
               rsp_in       = '0;
               rsp_in.status = ptm_pkg::STATUS_OK;
               if (err_ff) begin
                  rsp_in.status = ptm_pkg::STATUS_BAD_ID;
               end else begin
                  case (op_ff) inside
                     ptm_pkg::OP_SET, ptm_pkg::OP_COMPARE: begin
                        last_en              = 1'b1;
                        rsp_in.compare_valid = 1'b1;
                        rsp_in.compare_value = now_ff + min_ff;
                        if (op_ff == ptm_pkg::OP_COMPARE) begin
                           rsp_in.fired_mask = mask_ff;
                           rsp_in.irq_clear  = 1'b1;
                        end
                     end
                     ptm_pkg::OP_REMOVE: begin
                        if (!rd_active) begin
                           rsp_in.status = ptm_pkg::STATUS_INACTIVE;
                        end else begin
                           wr_en        = 1'b1;
                           wr_interval  = 32'd0;
                           wr_remaining = 32'd0;
                           wr_count     = 32'd0;
                        end
                     end
                     default: begin
                        rsp_in.entry_interval   = rd_interval;
                        rsp_in.entry_remaining  = rd_remaining;
                        rsp_in.entry_fire_count = rd_count;
                     end
                  endcase
               end
            end
         end

         default: begin
            state_in = ptm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 32'd0;
         for (int k = 0; k < NUM_TIMERS; k++) begin
            interval_ff[k]  <= 32'd0;
            remaining_ff[k] <= 32'd0;
            count_ff[k]     <= 32'd0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (last_en) begin
            last_ff <= now_ff;
         end
         if (wr_en) begin
            interval_ff[idx_ff]  <= wr_interval;
            remaining_ff[idx_ff] <= wr_remaining;
            count_ff[idx_ff]     <= wr_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      id_ff    <= id_in;
      op_ff    <= op_in;
      err_ff   <= err_in;
      ival_ff  <= ival_in;
      now_ff   <= now_in;
      diff_ff  <= diff_in;
      least_ff <= least_in;
      min_ff   <= min_in;
      mask_ff  <= mask_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// File: bench/tb_periodic_timer_multiplexer.sv
module tb_periodic_timer_multiplexer;

   localparam int NUM_TIMERS = 10;
   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT = 5000;
   localparam int STALL_AT = 400;
   localparam int STALL_CYCLES = 400;
   localparam int PAUSE_ITEM = 750;

   logic clock;
   logic reset;

   ptm_channel_if #(.payload_type(ptm_pkg::req_payload_type)) req_chan ();
   ptm_channel_if #(.payload_type(ptm_pkg::rsp_payload_type)) rsp_chan ();

   periodic_timer_multiplexer #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [31:0] tbl_interval  [NUM_TIMERS];
   logic [31:0] tbl_remaining [NUM_TIMERS];
   logic [31:0] tbl_fired     [NUM_TIMERS];
   logic [31:0] tbl_last_time;

   ptm_pkg::rsp_payload_type pending_rsp_q [$];
   ptm_pkg::req_payload_type directed_req [$];
   bit                       directed_lit [$];
   ptm_pkg::rsp_payload_type directed_rsp [$];

   bit                       lit_valid;
   ptm_pkg::rsp_payload_type lit_rsp;
   int unsigned              req_beats;
   int unsigned              rsp_beats;
   int unsigned              idle_cycles;
   int unsigned              error_count;
   ptm_pkg::rsp_payload_type predicted;
   ptm_pkg::rsp_payload_type wanted;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] min_active_remaining();
      logic [31:0] least;
      least = ptm_pkg::NO_ACTIVE_MIN;
      for (int k = 0; k < NUM_TIMERS; k++) begin
         if (tbl_interval[k] != 32'd0 && tbl_remaining[k] < least) begin
            least = tbl_remaining[k];
         end
      end
      return least;
   endfunction

   function automatic ptm_pkg::rsp_payload_type plain_rsp(ptm_pkg::status_type s, logic cv,
                                                          logic [31:0] cval, logic clr);
      ptm_pkg::rsp_payload_type r;
      r = '0;
      r.status = s;
      r.compare_valid = cv;
      r.compare_value = cval;
      r.irq_clear = clr;
      return r;
   endfunction

   function automatic ptm_pkg::rsp_payload_type timer_table_step(ptm_pkg::req_payload_type q);
      ptm_pkg::rsp_payload_type r;
      logic [31:0]              least;
      logic [31:0]              diff;
      ptm_pkg::fire_mask_type   mask;
      int                       id;
      r = plain_rsp(ptm_pkg::STATUS_OK, 1'b0, 32'd0, 1'b0);
      id = int'(q.slot_id);
      mask = '0;
      if (q.operation == ptm_pkg::OP_COMPARE) begin
         least = min_active_remaining();
         for (int k = 0; k < NUM_TIMERS; k++) begin
            if (tbl_interval[k] != 32'd0) begin
               tbl_remaining[k] = tbl_remaining[k] - least;
               if (tbl_remaining[k] == 32'd0) begin
                  tbl_remaining[k] = tbl_interval[k];
                  tbl_fired[k] = tbl_fired[k] + 32'd1;
                  if (k < ptm_pkg::FIRE_W) begin
                     mask[k] = 1'b1;
                  end
               end
            end
         end
         tbl_last_time = q.counter_now;
         r.compare_valid = 1'b1;
         r.compare_value = q.counter_now + min_active_remaining();
         r.fired_mask = mask;
         r.irq_clear = 1'b1;
      end else if (id >= NUM_TIMERS) begin
         r.status = ptm_pkg::STATUS_BAD_ID;
      end else if (q.operation == ptm_pkg::OP_SET) begin
         diff = q.counter_now - tbl_last_time;
         tbl_interval[id] = q.interval_us;
         tbl_remaining[id] = q.interval_us;
         tbl_fired[id] = 32'd0;
         for (int k = 0; k < NUM_TIMERS; k++) begin
            if (k != id && tbl_interval[k] != 32'd0) begin
               tbl_remaining[k] = tbl_remaining[k] - diff;
            end
         end
         tbl_last_time = q.counter_now;
         r.compare_valid = 1'b1;
         r.compare_value = q.counter_now + min_active_remaining();
      end else if (q.operation == ptm_pkg::OP_REMOVE) begin
         if (tbl_interval[id] == 32'd0) begin
            r.status = ptm_pkg::STATUS_INACTIVE;
         end else begin
            tbl_interval[id] = 32'd0;
            tbl_remaining[id] = 32'd0;
            tbl_fired[id] = 32'd0;
         end
      end else begin
         r.entry_interval = tbl_interval[id];
         r.entry_remaining = tbl_remaining[id];
         r.entry_fire_count = tbl_fired[id];
      end
      return r;
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic ptm_pkg::req_payload_type random_request();
      ptm_pkg::req_payload_type q;
      int unsigned              pick;
      logic [31:0]              least;
      q = '0;
      least = min_active_remaining();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         q.operation = ptm_pkg::OP_SET;
      end else if (pick < 50) begin
         q.operation = ptm_pkg::OP_REMOVE;
      end else if (pick < 80) begin
         q.operation = ptm_pkg::OP_COMPARE;
      end else begin
         q.operation = ptm_pkg::OP_QUERY;
      end
      pick = $urandom_range(0, 99);
      q.slot_id = (pick < 85) ? 8'($urandom_range(0, NUM_TIMERS - 1))
                              : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         q.interval_us = $urandom_range(1, 200);
      end else if (pick < 70) begin
         q.interval_us = 32'd0;
      end else if (pick < 90) begin
         q.interval_us = $urandom;
      end else if (pick < 95) begin
         q.interval_us = 32'hffff_ffff;
      end else begin
         q.interval_us = 32'd1;
      end
      pick = $urandom_range(0, 99);
      if (q.operation == ptm_pkg::OP_COMPARE) begin
         if (pick < 75) begin
            q.counter_now = (least == ptm_pkg::NO_ACTIVE_MIN)
                            ? tbl_last_time + $urandom_range(0, 1000)
                            : tbl_last_time + least;
         end else if (pick < 90) begin
            q.counter_now = tbl_last_time + $urandom_range(0, 50);
         end else begin
            q.counter_now = $urandom;
         end
      end else begin
         if (pick < 80) begin
            q.counter_now = tbl_last_time
                            + $urandom_range(0, (least > 32'd1000) ? 1000 : int'(least));
         end else begin
            q.counter_now = $urandom;
         end
      end
      return q;
   endfunction

   task automatic add_row(ptm_pkg::op_type op, logic [7:0] id, logic [31:0] ival,
                          logic [31:0] now, bit lit, ptm_pkg::rsp_payload_type r);
      ptm_pkg::req_payload_type q;
      q.operation = op;
      q.slot_id = id;
      q.interval_us = ival;
      q.counter_now = now;
      directed_req.push_back(q);
      directed_lit.push_back(lit);
      directed_rsp.push_back(r);
   endtask

   task check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_beats++;
            if (pending_rsp_q.size() == 0) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               wanted = pending_rsp_q.pop_front();
               check_field("status", 32'(wanted.status), 32'(rsp_chan.payload.status));
               check_field("compare_valid", 32'(wanted.compare_valid),
                           32'(rsp_chan.payload.compare_valid));
               check_field("compare_value", wanted.compare_value,
                           rsp_chan.payload.compare_value);
               check_field("fired_mask", 32'(wanted.fired_mask),
                           32'(rsp_chan.payload.fired_mask));
               check_field("irq_clear", 32'(wanted.irq_clear),
                           32'(rsp_chan.payload.irq_clear));
               check_field("entry_interval", wanted.entry_interval,
                           rsp_chan.payload.entry_interval);
               check_field("entry_remaining", wanted.entry_remaining,
                           rsp_chan.payload.entry_remaining);
               check_field("entry_fire_count", wanted.entry_fire_count,
                           rsp_chan.payload.entry_fire_count);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            req_beats++;
            predicted = timer_table_step(req_chan.payload);
            pending_rsp_q.push_back(lit_valid ? lit_rsp : predicted);
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : rsp_sink
      int unsigned gap;
      bit          stall_done;
      stall_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!stall_done && req_beats >= STALL_AT) begin
            stall_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (STALL_CYCLES) @(negedge clock);
         end else begin
            gap = (rsp_beats >= 200 && rsp_beats < 300) ? 0 : idle_gap();
            if (gap == 0) begin
               rsp_chan.ready <= 1'b1;
               @(negedge clock);
            end else begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   end

   initial begin : req_source
      int unsigned              gap;
      int unsigned              seen;
      int                       total;
      ptm_pkg::req_payload_type item;
      ptm_pkg::rsp_payload_type none;
      reset = 1'b1;
      req_beats = 0;
      rsp_beats = 0;
      idle_cycles = 0;
      error_count = 0;
      lit_valid = 1'b0;
      lit_rsp = '0;
      tbl_last_time = 32'd0;
      for (int k = 0; k < NUM_TIMERS; k++) begin
         tbl_interval[k] = 32'd0;
         tbl_remaining[k] = 32'd0;
         tbl_fired[k] = 32'd0;
      end
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      none = '0;

      add_row(ptm_pkg::OP_QUERY, 8'd0, 32'd0, 32'd0, 1'b1,
              plain_rsp(ptm_pkg::STATUS_OK, 1'b0, 32'd0, 1'b0));
      add_row(ptm_pkg::OP_COMPARE, 8'd0, 32'd0, 32'd5, 1'b1,
              plain_rsp(ptm_pkg::STATUS_OK, 1'b1, 32'd4, 1'b1));
      add_row(ptm_pkg::OP_SET, 8'd10, 32'd100, 32'd7, 1'b1,
              plain_rsp(ptm_pkg::STATUS_BAD_ID, 1'b0, 32'd0, 1'b0));
      add_row(ptm_pkg::OP_REMOVE, 8'd255, 32'd0, 32'd7, 1'b1,
              plain_rsp(ptm_pkg::STATUS_BAD_ID, 1'b0, 32'd0, 1'b0));
      add_row(ptm_pkg::OP_QUERY, 8'd200, 32'd0, 32'd7, 1'b1,
              plain_rsp(ptm_pkg::STATUS_BAD_ID, 1'b0, 32'd0, 1'b0));
      add_row(ptm_pkg::OP_REMOVE, 8'd3, 32'd0, 32'd7, 1'b1,
              plain_rsp(ptm_pkg::STATUS_INACTIVE, 1'b0, 32'd0, 1'b0));
      add_row(ptm_pkg::OP_SET, 8'd0, 32'd100, 32'd10, 1'b0, none);
      add_row(ptm_pkg::OP_SET, 8'd1, 32'hffff_ffff, 32'd20, 1'b0, none);
      add_row(ptm_pkg::OP_SET, 8'd2, 32'd0, 32'd30, 1'b0, none);
      add_row(ptm_pkg::OP_QUERY, 8'd0, 32'd0, 32'd30, 1'b0, none);
      add_row(ptm_pkg::OP_COMPARE, 8'd77, 32'd0, 32'd110, 1'b0, none);
      add_row(ptm_pkg::OP_QUERY, 8'd0, 32'd0, 32'd110, 1'b0, none);
      add_row(ptm_pkg::OP_QUERY, 8'd1, 32'd0, 32'd110, 1'b0, none);
      add_row(ptm_pkg::OP_SET, 8'd5, 32'd10, 32'd200, 1'b0, none);
      add_row(ptm_pkg::OP_SET, 8'd6, 32'd5, 32'd210, 1'b0, none);
      add_row(ptm_pkg::OP_COMPARE, 8'd0, 32'd0, 32'd210, 1'b0, none);
      add_row(ptm_pkg::OP_QUERY, 8'd5, 32'd0, 32'd210, 1'b0, none);
      add_row(ptm_pkg::OP_SET, 8'd9, 32'd1, 32'd220, 1'b0, none);
      add_row(ptm_pkg::OP_COMPARE, 8'd0, 32'd0, 32'd221, 1'b0, none);
      add_row(ptm_pkg::OP_QUERY, 8'd9, 32'd0, 32'd221, 1'b0, none);
      add_row(ptm_pkg::OP_REMOVE, 8'd0, 32'd0, 32'd221, 1'b0, none);
      add_row(ptm_pkg::OP_QUERY, 8'd0, 32'd0, 32'd221, 1'b0, none);
      add_row(ptm_pkg::OP_SET, 8'd9, 32'hffff_ffff, 32'hffff_ffff, 1'b0, none);
      add_row(ptm_pkg::OP_COMPARE, 8'd255, 32'hffff_ffff, 32'hffff_ffff, 1'b0, none);
      add_row(ptm_pkg::OP_QUERY, 8'd2, 32'd0, 32'hffff_ffff, 1'b0, none);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      total = directed_req.size() + RANDOM_ITEMS;
      for (int i = 0; i < total; i++) begin
         gap = ((i >= 200 && i < 300) || (i >= STALL_AT - 5 && i < STALL_AT + 70))
               ? 0 : idle_gap();
         if (i == PAUSE_ITEM) begin
            req_chan.valid <= 1'b0;
            do @(negedge clock); while (pending_rsp_q.size() != 0);
         end else if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         if (i < directed_req.size()) begin
            item = directed_req[i];
            lit_valid = directed_lit[i];
            lit_rsp = directed_rsp[i];
         end else begin
            item = random_request();
            lit_valid = 1'b0;
         end
         req_chan.payload <= item;
         req_chan.valid <= 1'b1;
         seen = req_beats;
         do @(negedge clock); while (req_beats == seen);
      end
      req_chan.valid <= 1'b0;

      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (2 * NUM_TIMERS + 8) @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
